// File: rtl/bid_pkg.sv
// Shared types and constants for the button ID entry / blink code block.
// No dependencies.
package bid_pkg;

  localparam int unsigned ID_COUNT   = 16;   // press counts 1..ID_COUNT-1 are valid ids
  localparam int unsigned HOLD_TICKS = 300;  // long-press length that arms entry

  localparam logic [8:0] HOLD_MAX         = 9'd511;
  localparam logic [4:0] PRESS_MAX        = 5'd31;
  localparam logic [9:0] ENTRY_IDLE_TICKS = 10'd300;
  localparam logic [9:0] ENTRY_HELD_TICKS = 10'd1000;
  localparam logic [3:0] TOGGLE_RELOAD    = 4'd10;

  // configuration register indexes
  localparam logic REG_ID_VALID  = 1'b0;
  localparam logic REG_ID_NUMBER = 1'b1;

  typedef struct packed {
    logic button_pressed;
    logic safety_on;
  } tick_t;

  typedef struct packed {
    logic       led_id;
    logic       led_tx;
    logic       led_rx;
    logic       entry_mode;
    logic       write_request;
    logic [3:0] new_id;
  } result_t;

  typedef struct packed {
    logic       idx;
    logic [3:0] wdata;
  } cfg_t;

  // debouncer state
  typedef struct packed {
    logic first;
    logic second;
  } deb_t;

  // controls from the tick logic to the blink sequencer
  typedef struct packed {
    logic       step;       // a blink section runs this beat
    logic       id_valid;
    logic [3:0] id_number;
    logic       led_in;     // ID LED level before the blink section
  } blink_ctl_t;

endpackage

// File: rtl/bid_chan_if.sv
// Valid/ready channel carrying one payload beat.
// Payload type is supplied per instance, usually from bid_pkg.
interface bid_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/bid_debounce.sv
// Two-bit button debouncer, evaluated twice in a row on one raw sample.
// Depends on bid_pkg.
module bid_debounce import bid_pkg::*; (
  input  deb_t st_i,
  input  logic pressed_i,
  output logic ans1_o,
  output deb_t st1_o,
  output logic ans2_o,
  output deb_t st2_o
);

  function automatic logic [2:0] deb_eval(input deb_t st, input logic p);
    deb_t n;
    logic a;
    n = st;
    a = 1'b0;
    if (p) begin
      if (st.first || st.second) begin
        n.second = 1'b1;
        a = 1'b1;
      end else begin
        n.first = 1'b1;
      end
    end else if (!st.first) begin
      n.second = 1'b0;
    end else begin
      n.first = 1'b0;
      a = st.second;
    end
    return {a, n};
  endfunction

  always_comb begin
    {ans1_o, st1_o} = deb_eval(st_i, pressed_i);
    {ans2_o, st2_o} = deb_eval(st1_o, pressed_i);
  end

endmodule

// File: rtl/bid_blink.sv
// Blink code sequencer: shows the stored id as id+1 pulses, then a pause.
// Depends on bid_pkg.
module bid_blink import bid_pkg::*; #(
  parameter int unsigned BLINK_TICKS = 20,
  parameter int unsigned PAUSE_TICKS = 100
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  blink_ctl_t ctl_i,
  output logic       led_o
);

  localparam int unsigned PhaseMax = 16 * 2 * BLINK_TICKS + PAUSE_TICKS + BLINK_TICKS;
  localparam int unsigned PhaseW   = $clog2(PhaseMax + 1);
  localparam int unsigned ModW     = (BLINK_TICKS > 1) ? $clog2(BLINK_TICKS) : 1;
  localparam logic [ModW-1:0]   ModLast   = ModW'(BLINK_TICKS - 1);
  localparam logic [ModW-1:0]   ModReload = ModW'(PAUSE_TICKS % BLINK_TICKS);
  localparam logic [PhaseW-1:0] QuietEnd  = PhaseW'(PAUSE_TICKS + BLINK_TICKS);

  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ModW-1:0]   mod_q, mod_d;     // phase_q mod BLINK_TICKS, tracked alongside
  logic [PhaseW-1:0] reload;

  always_comb begin
    reload  = PhaseW'({1'b0, ctl_i.id_number} + 5'd1) * PhaseW'(2 * BLINK_TICKS) + QuietEnd;
    phase_d = phase_q;
    mod_d   = mod_q;
    led_o   = ctl_i.led_in;
    if (!ctl_i.id_valid) begin
      led_o = 1'b1;
    end else begin
      if (phase_q <= QuietEnd) begin
        led_o = 1'b0;
      end else if (mod_q == '0) begin
        led_o = !ctl_i.led_in;
      end
      if (ctl_i.step) begin
        if (phase_q == '0) begin
          phase_d = reload;
          mod_d   = ModReload;
        end else begin
          phase_d = phase_q - PhaseW'(1);
          mod_d   = (mod_q == '0) ? ModLast : mod_q - ModW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      mod_q   <= '0;
    end else begin
      phase_q <= phase_d;
      mod_q   <= mod_d;
    end
  end

endmodule

// File: rtl/button_id_entry_and_blink_code_core.sv
// Top level of the button ID entry / blink code block.
// Depends on bid_pkg, bid_chan_if, bid_debounce and bid_blink.
//
// One tick beat (one 10 ms sample of the button and the safety flag) in gives one result beat
// out. The block takes a tick every clock cycle while tick_i.ready is high: the tick is
// worked in the cycle it is accepted, by the debouncer, the hold/entry logic and the blink
// sequencer, and the state and the result register load at that edge. The result register is
// the only buffer, so tick_i.ready follows result_o.ready while a result is waiting.
// A long press (HOLD_TICKS ticks with safety on) followed by release enters ID entry; presses
// are counted, TX/RX alternate every 11 ticks, and entry ends after 300 idle ticks (1000
// after a press while held). A count 1..ID_COUNT-1 raises write_request with new_id =
// count-1 on the ending tick. Outside entry the ID LED blinks id_number+1 pulses of
// BLINK_TICKS ticks, then pauses; with id_valid clear the ID LED stays lit.
// cfg_i is always ready; write it only while no tick is in flight.
module button_id_entry_and_blink_code_core import bid_pkg::*; #(
  parameter int unsigned BLINK_TICKS = 20,
  parameter int unsigned PAUSE_TICKS = 100
) (
  input logic       clk_i,
  input logic       rst_ni,
  bid_chan_if.sink   tick_i,
  bid_chan_if.source result_o,
  bid_chan_if.sink   cfg_i
);

  // configuration
  logic       id_valid_q;
  logic [3:0] id_number_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_valid_q  <= 1'b0;
      id_number_q <= 4'd0;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.idx)
        REG_ID_VALID:  id_valid_q  <= cfg_i.data.wdata[0];
        REG_ID_NUMBER: id_number_q <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  // tick state
  deb_t       deb_q, deb_d;
  logic [8:0] hold_q, hold_d;
  logic       entry_q, entry_d;
  logic [4:0] press_q, press_d;
  logic       latched_q, latched_d;
  logic [9:0] timeout_q, timeout_d;
  logic [3:0] div_q, div_d;
  logic       lid_q, tx_q, rx_q;
  logic       lid_mid, tx_d, rx_d;
  logic       wr, run_blink;
  logic [3:0] nid;
  logic [8:0] hold_inc;

  // result register
  logic    out_valid_q;
  result_t out_q;

  logic tick_acc;
  assign tick_i.ready = !out_valid_q || result_o.ready;
  assign tick_acc     = tick_i.valid && tick_i.ready;

  // debouncer, two evaluations on this beat's sample
  logic a1, a2;
  deb_t st1, st2;

  bid_debounce u_deb (
    .st_i      (deb_q),
    .pressed_i (tick_i.data.button_pressed),
    .ans1_o    (a1),
    .st1_o     (st1),
    .ans2_o    (a2),
    .st2_o     (st2)
  );

  // blink sequencer
  blink_ctl_t blink_ctl;
  logic       blink_led;

  assign blink_ctl.step      = tick_acc && run_blink;
  assign blink_ctl.id_valid  = id_valid_q;
  assign blink_ctl.id_number = id_number_q;
  assign blink_ctl.led_in    = lid_mid;

  bid_blink #(
    .BLINK_TICKS (BLINK_TICKS),
    .PAUSE_TICKS (PAUSE_TICKS)
  ) u_blink (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (blink_ctl),
    .led_o  (blink_led)
  );

  assign hold_inc = (hold_q < HOLD_MAX) ? hold_q + 9'd1 : hold_q;

  always_comb begin
    deb_d     = deb_q;
    hold_d    = hold_q;
    entry_d   = entry_q;
    press_d   = press_q;
    latched_d = latched_q;
    timeout_d = timeout_q;
    div_d     = div_q;
    lid_mid   = lid_q;
    tx_d      = tx_q;
    rx_d      = rx_q;
    wr        = 1'b0;
    nid       = 4'd0;
    run_blink = 1'b1;

    if (entry_q) begin
      deb_d = st2;
      // press edge from the first evaluation
      if (a1 && !latched_q) begin
        if (press_q < PRESS_MAX) press_d = press_q + 5'd1;
        lid_mid   = 1'b1;
        latched_d = 1'b1;
        timeout_d = ENTRY_HELD_TICKS;
      end
      // release edge from the second evaluation
      if (!a2 && latched_d) begin
        lid_mid   = 1'b0;
        latched_d = 1'b0;
        timeout_d = ENTRY_IDLE_TICKS;
      end
      if (div_q == 4'd0) begin
        tx_d  = !tx_q;
        rx_d  = !rx_q;
        div_d = TOGGLE_RELOAD;
      end else begin
        div_d = div_q - 4'd1;
      end
      if (timeout_d <= 10'd1) begin
        timeout_d = 10'd0;
        entry_d   = 1'b0;
        tx_d      = 1'b0;
        rx_d      = 1'b0;
        if (press_d != 5'd0 && {1'b0, press_d} < 6'(ID_COUNT)) begin
          wr  = 1'b1;
          nid = 4'(press_d - 5'd1);
        end
      end else begin
        timeout_d = timeout_d - 10'd1;
        run_blink = 1'b0;
      end
    end else if (tick_i.data.safety_on && a1) begin
      deb_d  = st1;
      hold_d = hold_inc;
      if (hold_inc >= 9'(HOLD_TICKS)) begin
        lid_mid = 1'b0;
        deb_d   = st2;
        if (!a2) begin
          // long press released: start entry
          entry_d   = 1'b1;
          press_d   = 5'd0;
          latched_d = 1'b0;
          timeout_d = ENTRY_IDLE_TICKS;
          div_d     = TOGGLE_RELOAD;
          tx_d      = 1'b1;
          rx_d      = 1'b0;
          run_blink = 1'b0;
        end
      end
    end else begin
      if (tick_i.data.safety_on) deb_d = st1;
      hold_d = 9'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_q     <= '0;
      hold_q    <= 9'd0;
      entry_q   <= 1'b0;
      press_q   <= 5'd0;
      latched_q <= 1'b0;
      timeout_q <= 10'd0;
      div_q     <= 4'd0;
      lid_q     <= 1'b0;
      tx_q      <= 1'b0;
      rx_q      <= 1'b0;
    end else if (tick_acc) begin
      deb_q     <= deb_d;
      hold_q    <= hold_d;
      entry_q   <= entry_d;
      press_q   <= press_d;
      latched_q <= latched_d;
      timeout_q <= timeout_d;
      div_q     <= div_d;
      lid_q     <= run_blink ? blink_led : lid_mid;
      tx_q      <= tx_d;
      rx_q      <= rx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (tick_acc) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      out_q.led_id        <= run_blink ? blink_led : lid_mid;
      out_q.led_tx        <= tx_d;
      out_q.led_rx        <= rx_d;
      out_q.entry_mode    <= entry_d;
      out_q.write_request <= wr;
      out_q.new_id        <= nid;
    end
  end

  assign result_o.valid = out_valid_q;
  assign result_o.data  = out_q;

  // TX and RX run in opposite phase during entry and are both dark outside it
  a_txrx_entry : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tx_q ^ rx_q) == entry_q)
    else $error("TX/RX levels disagree with entry state");

  // an active entry always has time left
  a_timeout_live : assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_q |-> timeout_q != 10'd0)
    else $error("entry active with expired timeout");

  // a write request comes only on the beat that leaves entry
  a_wr_exit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc && wr |=> !entry_q && $past(entry_q))
    else $error("write request outside entry exit");

  // every accepted tick leaves a result waiting
  a_tick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> result_o.valid)
    else $error("accepted tick produced no result");

endmodule

// File: test/button_id_entry_and_blink_code_core_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_id_entry_and_blink_code_core: tick beats in, one
// result beat per tick out, each predicted here and checked in order.
// Depends on bid_pkg, bid_chan_if and the core RTL.
module button_id_entry_and_blink_code_core_tb;
  import bid_pkg::*;

  localparam int unsigned BLINK_TICKS = 20;
  localparam int unsigned PAUSE_TICKS = 100;
  localparam int unsigned ITEM_COUNT  = 1350;       // random noise tops the run up to this
  localparam int unsigned CYCLE_LIMIT = 5_000_000;  // slowest legal run is far below this

  logic clk;
  logic rst_n;

  bid_chan_if #(.payload_t(tick_t))   tick_ch ();
  bid_chan_if #(.payload_t(result_t)) result_ch ();
  bid_chan_if #(.payload_t(cfg_t))    cfg_ch ();

  button_id_entry_and_blink_code_core #(
    .BLINK_TICKS(BLINK_TICKS),
    .PAUSE_TICKS(PAUSE_TICKS)
  ) uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .tick_i  (tick_ch.sink),
    .result_o(result_ch.source),
    .cfg_i   (cfg_ch.sink)
  );

  // ---------------------------------------------------------------------------
  // Predictor state: a per-tick copy of the block's registers and its config.
  // ---------------------------------------------------------------------------
  logic       cfg_id_valid;
  logic [3:0] cfg_id_number;
  logic       deb_first;
  logic       deb_second;
  logic [8:0] hold_ticks;
  logic       in_entry;
  logic [4:0] press_total;
  logic       press_held;
  logic [9:0] entry_left;
  logic [3:0] toggle_div;
  logic [9:0] blink_count;
  logic       lamp_id;
  logic       lamp_tx;
  logic       lamp_rx;

  result_t expected_results[$];

  int unsigned errors       = 0;
  int unsigned ticks_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned entry_starts = 0;
  int unsigned id_writes    = 0;
  int unsigned cycles       = 0;

  // Traffic shaping, shared by the tests and the result sink.
  bit gaps_on       = 1'b1;
  bit stalls_on     = 1'b1;
  int hold_off_left = 0;   // cycles the sink must keep ready low

  // ---------------------------------------------------------------------------
  // Clock, cycle limit
  // ---------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached", $time);
      $display("button_id_entry_and_blink_code_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void clear_tick_state();
    cfg_id_valid  = 1'b0;
    cfg_id_number = '0;
    deb_first     = 1'b0;
    deb_second    = 1'b0;
    hold_ticks    = '0;
    in_entry      = 1'b0;
    press_total   = '0;
    press_held    = 1'b0;
    entry_left    = '0;
    toggle_div    = '0;
    blink_count   = '0;
    lamp_id       = 1'b0;
    lamp_tx       = 1'b0;
    lamp_rx       = 1'b0;
  endfunction

  // Two-bit debouncer; the block may sample it twice in one tick.
  function automatic logic debounce_sample(logic button);
    if (button) begin
      if (deb_first || deb_second) begin
        deb_second = 1'b1;
        return 1'b1;
      end
      deb_first = 1'b1;
      return 1'b0;
    end
    if (!deb_first) begin
      deb_second = 1'b0;
      return 1'b0;
    end
    deb_first = 1'b0;
    return deb_second;
  endfunction

  // id+1 pulses of BLINK_TICKS, then the pause; lit solid without a stored id
  function automatic void blink_step();
    if (!cfg_id_valid) begin
      lamp_id = 1'b1;
      return;
    end
    if (blink_count <= PAUSE_TICKS + BLINK_TICKS) lamp_id = 1'b0;
    else if (blink_count % BLINK_TICKS == 0) lamp_id = !lamp_id;
    if (blink_count == '0)
      blink_count = 10'((int'(cfg_id_number) + 1) * 2 * BLINK_TICKS
                        + PAUSE_TICKS + BLINK_TICKS);
    else
      blink_count = blink_count - 1'b1;
  endfunction

  function automatic result_t predict_tick(logic button, logic safety);
    result_t res;
    logic    hit_a;
    logic    hit_b;
    logic    run_blink;
    res       = '0;
    hit_a     = 1'b0;
    run_blink = 1'b1;
    if (in_entry) begin
      // first sample counts a new press, second sample sees its release
      hit_a = debounce_sample(button);
      if (hit_a && !press_held) begin
        if (press_total < PRESS_MAX) press_total = press_total + 1'b1;
        lamp_id    = 1'b1;
        press_held = 1'b1;
        entry_left = ENTRY_HELD_TICKS;
      end
      hit_b = debounce_sample(button);
      if (!hit_b && press_held) begin
        lamp_id    = 1'b0;
        press_held = 1'b0;
        entry_left = ENTRY_IDLE_TICKS;
      end
      if (toggle_div == '0) begin
        lamp_tx    = !lamp_tx;
        lamp_rx    = !lamp_rx;
        toggle_div = TOGGLE_RELOAD;
      end else begin
        toggle_div = toggle_div - 1'b1;
      end
      if (entry_left <= 10'd1) begin
        entry_left = '0;
        in_entry   = 1'b0;
        lamp_tx    = 1'b0;
        lamp_rx    = 1'b0;
        if (press_total != '0 && press_total < ID_COUNT) begin
          res.write_request = 1'b1;
          res.new_id        = 4'(press_total - 1'b1);
          id_writes++;
        end
      end else begin
        entry_left = entry_left - 1'b1;
        run_blink  = 1'b0;
      end
    end else begin
      if (safety) hit_a = debounce_sample(button);
      if (hit_a) begin
        if (hold_ticks < HOLD_MAX) hold_ticks = hold_ticks + 1'b1;
        if (hold_ticks >= HOLD_TICKS) begin
          lamp_id = 1'b0;
          // release after a long hold arms entry
          if (!debounce_sample(button)) begin
            in_entry    = 1'b1;
            press_total = '0;
            press_held  = 1'b0;
            entry_left  = ENTRY_IDLE_TICKS;
            toggle_div  = TOGGLE_RELOAD;
            lamp_tx     = 1'b1;
            lamp_rx     = 1'b0;
            run_blink   = 1'b0;
            entry_starts++;
          end
        end
      end else begin
        hold_ticks = '0;   // note: entry exit leaves hold_ticks stale on purpose
      end
    end
    if (run_blink) blink_step();
    res.led_id     = lamp_id;
    res.led_tx     = lamp_tx;
    res.led_rx     = lamp_rx;
    res.entry_mode = in_entry;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking, sampled at the rising edge
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: result beat with none expected, expected none, actual %p",
               $time, got);
      return;
    end
    want = expected_results.pop_front();
    results_seen++;
    check_field("led_id", want.led_id, got.led_id);
    check_field("led_tx", want.led_tx, got.led_tx);
    check_field("led_rx", want.led_rx, got.led_rx);
    check_field("entry_mode", want.entry_mode, got.entry_mode);
    check_field("write_request", want.write_request, got.write_request);
    check_field("new_id", want.new_id, got.new_id);
  endtask

  always @(posedge clk) begin
    if (rst_n && result_ch.valid && result_ch.ready) check_result(result_ch.data);
  end

  // ---------------------------------------------------------------------------
  // Result sink: random stalls, plus a long counted hold-off on request
  // ---------------------------------------------------------------------------
  function automatic int pick_stretch();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : result_sink
    int stall_left;
    stall_left      = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        hold_off_left--;
        result_ch.ready <= 1'b0;
      end else begin
        if (stall_left == 0 && stalls_on && $urandom_range(0, 99) < 25)
          stall_left = pick_stretch();
        if (stall_left > 0) begin
          stall_left--;
          result_ch.ready <= 1'b0;
        end else begin
          result_ch.ready <= 1'b1;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers. Every task starts and ends at a falling edge. send_tick leaves valid
  // high so back-to-back beats never lower and raise it in the same step.
  // ---------------------------------------------------------------------------
  task automatic send_tick(logic button, logic safety);
    int gap;
    gap = 0;
    if (gaps_on && $urandom_range(0, 99) >= 60) gap = pick_stretch();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      tick_ch.data  <= tick_t'(2'($urandom));
      repeat (gap) @(negedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= '{button_pressed: button, safety_on: safety};
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    expected_results.push_back(predict_tick(button, safety));
    ticks_sent++;
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding result; each tick gives one result,
  // so an empty queue means the block is idle.
  task automatic wait_results_done();
    tick_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [3:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= {idx, value};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_ID_VALID) cfg_id_valid = value[0];
    else cfg_id_number = value;
    @(negedge clk);
  endtask

  // only called with at least one tick between calls
  task automatic set_config(logic id_ok, logic [3:0] id_num);
    wait_results_done();
    write_reg(REG_ID_VALID, {3'b000, id_ok});
    write_reg(REG_ID_NUMBER, id_num);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  // Long press with safety on, then release.
  task automatic arm_entry(int hold_target);
    while (!in_entry) begin
      if (hold_ticks < hold_target && hold_ticks != HOLD_MAX)
        send_tick(1'b1, 1'b1);
      else
        send_tick(1'b0, 1'b1);
    end
  endtask

  // n short presses; safety is don't-care inside entry
  task automatic press_burst(int n);
    repeat (n) begin
      repeat ($urandom_range(1, 3)) send_tick(1'b1, 1'($urandom));
      repeat ($urandom_range(1, 4)) send_tick(1'b0, 1'($urandom));
    end
  endtask

  // Idle out the entry timeout. With rearm, press on the closing tick so that
  // the stale hold count lets the next release re-enter at once.
  task automatic leave_entry(bit rearm);
    while (in_entry) begin
      if (rearm && entry_left <= 10'd1 && !press_held) send_tick(1'b1, 1'b1);
      else send_tick(1'b0, 1'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Short directed run at reset config (ID LED solid): all field combinations,
  // a short hold that never arms, bounces.
  task automatic test_field_extremes();
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
  endtask

  // One full blink cycle of the shortest id; it ends on a blink step that reloads
  // the phase from the id stored then, so the phase is not left at zero.
  task automatic test_blink_code();
    set_config(1'b1, 4'd0);
    repeat (162) send_tick(1'($urandom), 1'b0);
  endtask

  // Longest id blinks through the long hold. Press counts: highest id, then past
  // the counter ceiling. The second session re-arms from the stale hold count.
  task automatic test_entry_counts();
    int counts[2];
    counts = '{15, 33};
    set_config(1'b1, 4'd15);
    foreach (counts[i]) begin
      arm_entry(HOLD_TICKS);
      press_burst(counts[i]);
      leave_entry(i == 0);
    end
  endtask

  // Sink holds off for a long stretch while beats keep coming, then the
  // sender waits for every result before going on.
  task automatic test_backpressure();
    gaps_on       = 1'b0;
    hold_off_left = 100;
    repeat (30) send_tick(1'($urandom), 1'($urandom));
    wait_results_done();
    repeat (10) send_tick(1'($urandom), 1'($urandom));
    gaps_on = 1'b1;
  endtask

  // Random noise bursts with config changes until the tick budget is used.
  task automatic test_random_noise();
    while (ticks_sent < ITEM_COUNT) begin
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 3))
          0: set_config(1'b0, 4'($urandom));
          1: set_config(1'b1, 4'd0);
          2: set_config(1'b1, 4'd15);
          default: set_config(1'b1, 4'($urandom));
        endcase
      end
      repeat ($urandom_range(5, 20)) send_tick(1'($urandom), 1'($urandom));
    end
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    tick_ch.valid = 1'b0;
    tick_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    clear_tick_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_field_extremes();
    test_blink_code();
    test_entry_counts();
    test_backpressure();
    test_random_noise();

    wait_results_done();
    repeat (8) @(negedge clk);   // catch any stray result beat

    $display("Checked %0d result beats from %0d ticks; %0d entry sessions, %0d id writes.",
             results_seen, ticks_sent, entry_starts, id_writes);
    $display("Covered debounce noise, long holds, stale re-arm, press counts 15 and 33, %s",
             "blink codes for ids 0 and 15 and result back-pressure.");
    if (errors == 0) begin
      $display("button_id_entry_and_blink_code_core regression: pass");
    end else begin
      $display("button_id_entry_and_blink_code_core regression: fail");
    end
    $finish;
  end

endmodule
